### sv/cmsp_pkg.sv
// cmsp_pkg: shared types and constants for the coap message stream parser
// record layout, record kinds, status codes and parser phases
// no dependencies
package cmsp_pkg;

  localparam int MaxOptionsDefault = 16;

  localparam int InDataW  = 8;
  localparam int OutDataW = 80;
  localparam int KindW    = 3;

  localparam logic [7:0]  PayloadMarker = 8'hFF;
  localparam logic [3:0]  NibbleExt1    = 4'd13;
  localparam logic [3:0]  NibbleExt2    = 4'd14;
  localparam logic [3:0]  NibbleBad     = 4'd15;
  localparam logic [15:0] Ext1Base      = 16'd13;
  localparam logic [15:0] Ext2Base      = 16'd269;
  localparam logic [3:0]  MaxTokenLen   = 4'd8;
  localparam logic [1:0]  CoapVersion   = 2'b01;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_TOKEN   = 3'd1,
    KIND_OPTION  = 3'd2,
    KIND_VALUE   = 3'd3,
    KIND_PAYLOAD = 3'd4,
    KIND_END     = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    STAT_OK          = 3'd0,
    STAT_SHORT_HDR   = 3'd1,
    STAT_BAD_VERSION = 3'd2,
    STAT_BAD_TOKEN   = 3'd3,
    STAT_SHORT_OPT   = 3'd4,
    STAT_DELTA_15    = 3'd5,
    STAT_LENGTH_15   = 3'd6,
    STAT_OPT_OVERRUN = 3'd7
  } status_e;

  typedef enum logic [7:0] {
    PH_HDR = 8'b0000_0001,
    PH_TOK = 8'b0000_0010,
    PH_OPT = 8'b0000_0100,
    PH_EXT = 8'b0000_1000,
    PH_VAL = 8'b0001_0000,
    PH_PAY = 8'b0010_0000,
    PH_IGN = 8'b0100_0000,
    PH_ERR = 8'b1000_0000
  } phase_e;

  // fields listed from the highest bit down, msg_type in the lowest bits
  typedef struct packed {
    status_e     status;
    logic [4:0]  option_count;
    logic [7:0]  byte_out;
    logic [15:0] option_length;
    logic [15:0] option_number;
    logic [15:0] message_id;
    logic [7:0]  code;
    logic [3:0]  token_length;
    logic [1:0]  msg_type;
  } rec_data_t;

  typedef struct packed {
    logic      last;
    kind_e     kind;
    rec_data_t data;
  } rec_t;

endpackage

### sv/coap_message_stream_parser_core.sv
// coap_message_stream_parser_core: one-byte-per-transfer coap message parser
// with a four-entry record queue on the output side; uses cmsp_pkg
// a record enters the queue at its byte's transfer, behind any earlier records
// throughput: one byte per cycle; the final byte of a packet may queue two records,
// and s_axis_tready is low only while three or more records wait in the queue
// reset: asynchronous active-low rst_ni clears the parser state and empties the queue
module coap_message_stream_parser_core #(
  parameter int MaxOptions = cmsp_pkg::MaxOptionsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [cmsp_pkg::InDataW-1:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic                          s_axis_tlast,  // end_of_packet
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [1:0] msg_type, [5:2] token_length, [13:6] code, [29:14] message_id,
  // [45:30] option_number, [61:46] option_length, [69:62] byte_out,
  // [74:70] option_count, [77:75] status, [79:78] zero
  output logic [cmsp_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [cmsp_pkg::KindW-1:0]    m_axis_tuser,  // [2:0] kind
  output logic                          m_axis_tlast   // last
);

  localparam int CntW    = $clog2(MaxOptions + 1);
  localparam int QDepth  = 4;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);
  localparam int RecDW   = $bits(cmsp_pkg::rec_data_t);

  cmsp_pkg::phase_e  phase_q, phase_d;
  logic [1:0]        hdr_cnt_q, hdr_cnt_d;
  logic [23:0]       hold_q, hold_d;
  logic [15:0]       rem_q, rem_d;
  logic [15:0]       run_q, run_d;
  logic [15:0]       delta_q, delta_d;
  logic [15:0]       len_q, len_d;
  logic [1:0]        dp_q, dp_d;
  logic [1:0]        lp_q, lp_d;
  logic [CntW-1:0]   opt_cnt_q, opt_cnt_d;
  cmsp_pkg::status_e err_q, err_d;

  cmsp_pkg::rec_t    main_rec, end_rec;
  logic              have;
  logic              accept;
  logic [7:0]        b;
  logic              eop;

  cmsp_pkg::rec_t    queue_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  q_cnt_q;
  logic              push_main, push_end, pop;

  assign b      = s_axis_tdata;
  assign eop    = s_axis_tlast;
  assign accept = s_axis_tvalid & s_axis_tready;

  always_comb begin
    logic [31:0]       hold_full;
    logic              do_start;
    logic [15:0]       st_delta;
    logic [3:0]        st_lnib;
    logic              do_comp;
    logic [15:0]       cp_delta;
    logic [15:0]       cp_len;
    logic [15:0]       num;
    logic [15:0]       sum;
    logic              fail;
    cmsp_pkg::status_e fail_code;
    cmsp_pkg::status_e st;

    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    hold_d    = hold_q;
    rem_d     = rem_q;
    run_d     = run_q;
    delta_d   = delta_q;
    len_d     = len_q;
    dp_d      = dp_q;
    lp_d      = lp_q;
    opt_cnt_d = opt_cnt_q;
    err_d     = err_q;

    main_rec      = '0;
    main_rec.kind = cmsp_pkg::KIND_HEADER;
    have          = 1'b0;
    hold_full     = {hold_q, b};
    do_start      = 1'b0;
    st_delta      = delta_q;
    st_lnib       = len_q[3:0];
    do_comp       = 1'b0;
    cp_delta      = delta_q;
    cp_len        = len_q;
    num           = '0;
    sum           = '0;
    fail          = 1'b0;
    fail_code     = cmsp_pkg::STAT_OK;
    st            = cmsp_pkg::STAT_OK;

    case (phase_q)
      cmsp_pkg::PH_HDR: begin
        if (hdr_cnt_q != 2'd3) begin
          hold_d    = {hold_q[15:0], b};
          hdr_cnt_d = hdr_cnt_q + 2'd1;
        end else begin
          hdr_cnt_d = 2'd0;
          if (hold_full[31:30] != cmsp_pkg::CoapVersion) begin
            fail      = 1'b1;
            fail_code = cmsp_pkg::STAT_BAD_VERSION;
          end else if (hold_full[27:24] > cmsp_pkg::MaxTokenLen) begin
            fail      = 1'b1;
            fail_code = cmsp_pkg::STAT_BAD_TOKEN;
          end else begin
            main_rec.kind              = cmsp_pkg::KIND_HEADER;
            main_rec.data.msg_type     = hold_full[29:28];
            main_rec.data.token_length = hold_full[27:24];
            main_rec.data.code         = hold_full[23:16];
            main_rec.data.message_id   = hold_full[15:0];
            have    = 1'b1;
            rem_d   = {12'd0, hold_full[27:24]};
            phase_d = (hold_full[27:24] != 4'd0) ? cmsp_pkg::PH_TOK : cmsp_pkg::PH_OPT;
          end
        end
      end
      cmsp_pkg::PH_TOK: begin
        main_rec.kind          = cmsp_pkg::KIND_TOKEN;
        main_rec.data.byte_out = b;
        have  = 1'b1;
        rem_d = rem_q - 16'd1;
        if (rem_q == 16'd1) begin
          phase_d = cmsp_pkg::PH_OPT;
        end
      end
      cmsp_pkg::PH_OPT: begin
        if (b == cmsp_pkg::PayloadMarker) begin
          phase_d = cmsp_pkg::PH_PAY;
        end else if (opt_cnt_q >= CntW'(MaxOptions)) begin
          phase_d = cmsp_pkg::PH_IGN;
        end else begin
          len_d = {12'd0, b[3:0]};
          if (b[7:4] == cmsp_pkg::NibbleBad) begin
            fail      = 1'b1;
            fail_code = cmsp_pkg::STAT_DELTA_15;
          end else if (b[7:4] == cmsp_pkg::NibbleExt1) begin
            delta_d = cmsp_pkg::Ext1Base;
            dp_d    = 2'd1;
            lp_d    = 2'd0;
            phase_d = cmsp_pkg::PH_EXT;
          end else if (b[7:4] == cmsp_pkg::NibbleExt2) begin
            delta_d = cmsp_pkg::Ext2Base;
            dp_d    = 2'd2;
            lp_d    = 2'd0;
            phase_d = cmsp_pkg::PH_EXT;
          end else begin
            do_start = 1'b1;
            st_delta = {12'd0, b[7:4]};
            st_lnib  = b[3:0];
          end
        end
      end
      cmsp_pkg::PH_EXT: begin
        if (dp_q != 2'd0) begin
          sum     = delta_q + ((dp_q == 2'd2) ? {b, 8'h00} : {8'h00, b});
          delta_d = sum;
          dp_d    = dp_q - 2'd1;
          lp_d    = 2'd0;
          if (dp_q == 2'd1) begin
            do_start = 1'b1;
            st_delta = sum;
            st_lnib  = len_q[3:0];
          end
        end else if (lp_q != 2'd0) begin
          sum   = len_q + ((lp_q == 2'd2) ? {b, 8'h00} : {8'h00, b});
          len_d = sum;
          lp_d  = lp_q - 2'd1;
          dp_d  = 2'd0;
          if (lp_q == 2'd1) begin
            do_comp  = 1'b1;
            cp_delta = delta_q;
            cp_len   = sum;
          end
        end else begin
          do_comp  = 1'b1;
          cp_delta = delta_q;
          cp_len   = len_q;
        end
      end
      cmsp_pkg::PH_VAL: begin
        main_rec.kind          = cmsp_pkg::KIND_VALUE;
        main_rec.data.byte_out = b;
        have  = 1'b1;
        rem_d = rem_q - 16'd1;
        if (rem_q == 16'd1) begin
          phase_d = cmsp_pkg::PH_OPT;
        end
      end
      cmsp_pkg::PH_PAY: begin
        main_rec.kind          = cmsp_pkg::KIND_PAYLOAD;
        main_rec.data.byte_out = b;
        have = 1'b1;
      end
      default: begin
      end
    endcase

    // length nibble handling once the delta is known
    if (do_start) begin
      delta_d = st_delta;
      if (st_lnib == cmsp_pkg::NibbleBad) begin
        fail      = 1'b1;
        fail_code = cmsp_pkg::STAT_LENGTH_15;
      end else if (st_lnib == cmsp_pkg::NibbleExt1) begin
        len_d   = cmsp_pkg::Ext1Base;
        lp_d    = 2'd1;
        dp_d    = 2'd0;
        phase_d = cmsp_pkg::PH_EXT;
      end else if (st_lnib == cmsp_pkg::NibbleExt2) begin
        len_d   = cmsp_pkg::Ext2Base;
        lp_d    = 2'd2;
        dp_d    = 2'd0;
        phase_d = cmsp_pkg::PH_EXT;
      end else begin
        do_comp  = 1'b1;
        cp_delta = st_delta;
        cp_len   = {12'd0, st_lnib};
        len_d    = cp_len;
      end
    end

    if (do_comp) begin
      num       = run_q + cp_delta;
      run_d     = num;
      opt_cnt_d = opt_cnt_q + CntW'(1);
      dp_d      = 2'd0;
      lp_d      = 2'd0;
      rem_d     = cp_len;
      main_rec.kind               = cmsp_pkg::KIND_OPTION;
      main_rec.data.option_number = num;
      main_rec.data.option_length = cp_len;
      have    = 1'b1;
      phase_d = (cp_len != 16'd0) ? cmsp_pkg::PH_VAL : cmsp_pkg::PH_OPT;
    end

    if (fail) begin
      err_d   = fail_code;
      phase_d = cmsp_pkg::PH_ERR;
    end

    case (phase_d)
      cmsp_pkg::PH_ERR: st = err_d;
      cmsp_pkg::PH_HDR: st = cmsp_pkg::STAT_SHORT_HDR;
      cmsp_pkg::PH_TOK: st = cmsp_pkg::STAT_BAD_TOKEN;
      cmsp_pkg::PH_EXT: st = cmsp_pkg::STAT_SHORT_OPT;
      cmsp_pkg::PH_VAL: st = cmsp_pkg::STAT_OPT_OVERRUN;
      default:          st = cmsp_pkg::STAT_OK;
    endcase

    end_rec      = '0;
    end_rec.kind = cmsp_pkg::KIND_END;
    end_rec.last = 1'b1;
    end_rec.data.status = st;
    end_rec.data.option_count = (st == cmsp_pkg::STAT_OK) ? 5'(opt_cnt_d) : 5'd0;

    if (eop) begin
      if (st != cmsp_pkg::STAT_OK) begin
        have = 1'b0;
      end
      phase_d   = cmsp_pkg::PH_HDR;
      hdr_cnt_d = 2'd0;
      hold_d    = '0;
      rem_d     = '0;
      run_d     = '0;
      delta_d   = '0;
      len_d     = '0;
      dp_d      = 2'd0;
      lp_d      = 2'd0;
      opt_cnt_d = '0;
      err_d     = cmsp_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= cmsp_pkg::PH_HDR;
      hdr_cnt_q <= 2'd0;
      hold_q    <= '0;
      rem_q     <= '0;
      run_q     <= '0;
      delta_q   <= '0;
      len_q     <= '0;
      dp_q      <= 2'd0;
      lp_q      <= 2'd0;
      opt_cnt_q <= '0;
      err_q     <= cmsp_pkg::STAT_OK;
    end else if (accept) begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      hold_q    <= hold_d;
      rem_q     <= rem_d;
      run_q     <= run_d;
      delta_q   <= delta_d;
      len_q     <= len_d;
      dp_q      <= dp_d;
      lp_q      <= lp_d;
      opt_cnt_q <= opt_cnt_d;
      err_q     <= err_d;
    end
  end

  // record queue
  assign push_main = accept & have;
  assign push_end  = accept & eop;
  assign pop       = m_axis_tvalid & m_axis_tready;

  assign s_axis_tready = (q_cnt_q <= QCntW'(QDepth - 2));
  assign m_axis_tvalid = (q_cnt_q != '0);
  assign m_axis_tdata  = {{(cmsp_pkg::OutDataW - RecDW){1'b0}}, queue_q[rd_ptr_q].data};
  assign m_axis_tuser  = queue_q[rd_ptr_q].kind;
  assign m_axis_tlast  = queue_q[rd_ptr_q].last;

  always_ff @(posedge clk_i) begin
    if (push_main) begin
      queue_q[wr_ptr_q] <= main_rec;
    end
    if (push_end) begin
      queue_q[push_main ? wr_ptr_q + QPtrW'(1) : wr_ptr_q] <= end_rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      q_cnt_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(push_main) + QPtrW'(push_end);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      q_cnt_q <= q_cnt_q + QCntW'(push_main) + QCntW'(push_end) - QCntW'(pop);
    end
  end

endmodule

### tb/coap_message_stream_parser_core_tb.sv
// coap_message_stream_parser_core_tb: self-checking bench for the coap message parser core
// drives message bytes with random gaps, predicts every record and checks the master side
// depends on cmsp_pkg and coap_message_stream_parser_core
module coap_message_stream_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cmsp_pkg::*;

  localparam int ClkPeriod  = 20;
  localparam int CycleLimit = 200000;
  localparam int DrainWait  = 20;

  typedef struct packed {
    logic [7:0] octet;
    logic       eop;
  } wire_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [KindW-1:0]    m_axis_tuser;
  logic                m_axis_tlast;

  wire_byte_t pending_bytes[$];
  rec_t       expected_records[$];
  logic [7:0] message_bytes[$];

  int send_idle_pct   = 0;
  int recv_stall_pct  = 0;
  int mismatch_count  = 0;
  int cycle_count     = 0;
  int bytes_queued    = 0;

  // parser state mirrored by the predictor
  phase_e      ps_phase;
  logic [1:0]  ps_hdr_cnt;
  logic [31:0] ps_hdr_word;
  logic [15:0] ps_remaining;
  logic [15:0] ps_opt_num;
  logic [15:0] ps_delta;
  logic [15:0] ps_length;
  logic [1:0]  ps_delta_ext;
  logic [1:0]  ps_length_ext;
  logic [4:0]  ps_opt_count;
  status_e     ps_error;

  coap_message_stream_parser_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    end
  endtask

  task automatic clear_parser();
    ps_phase      = PH_HDR;
    ps_hdr_cnt    = '0;
    ps_hdr_word   = '0;
    ps_remaining  = '0;
    ps_opt_num    = '0;
    ps_delta      = '0;
    ps_length     = '0;
    ps_delta_ext  = '0;
    ps_length_ext = '0;
    ps_opt_count  = '0;
    ps_error      = STAT_OK;
  endtask

  task automatic abort_packet(input status_e code);
    ps_error = code;
    ps_phase = PH_ERR;
  endtask

  task automatic finish_option(inout rec_t r, inout bit have);
    ps_opt_num    = ps_opt_num + ps_delta;
    ps_opt_count  = ps_opt_count + 5'd1;
    ps_delta_ext  = '0;
    ps_length_ext = '0;
    ps_remaining  = ps_length;
    r.kind               = KIND_OPTION;
    r.data.option_number = ps_opt_num;
    r.data.option_length = ps_length;
    have     = 1'b1;
    ps_phase = (ps_remaining != 0) ? PH_VAL : PH_OPT;
  endtask

  task automatic start_length(inout rec_t r, inout bit have);
    logic [3:0] nib;
    nib = ps_length[3:0];
    if (nib == NibbleBad) begin
      abort_packet(STAT_LENGTH_15);
    end else if (nib == NibbleExt1) begin
      ps_length     = Ext1Base;
      ps_length_ext = 2'd1;
      ps_phase      = PH_EXT;
    end else if (nib == NibbleExt2) begin
      ps_length     = Ext2Base;
      ps_length_ext = 2'd2;
      ps_phase      = PH_EXT;
    end else begin
      ps_length = {12'h000, nib};
      finish_option(r, have);
    end
  endtask

  // works out the records caused by one accepted byte
  task automatic predict_records(input logic [7:0] b, input logic eop);
    rec_t       r;
    bit         have;
    status_e    st;
    logic [3:0] tkl;
    r    = '0;
    have = 1'b0;
    case (ps_phase)
      PH_HDR: begin
        ps_hdr_word = {ps_hdr_word[23:0], b};
        if (ps_hdr_cnt < 2'd3) begin
          ps_hdr_cnt = ps_hdr_cnt + 2'd1;
        end else begin
          ps_hdr_cnt = '0;
          tkl = ps_hdr_word[27:24];
          if (ps_hdr_word[31:30] != CoapVersion) begin
            abort_packet(STAT_BAD_VERSION);
          end else if (tkl > MaxTokenLen) begin
            abort_packet(STAT_BAD_TOKEN);
          end else begin
            r.kind              = KIND_HEADER;
            r.data.msg_type     = ps_hdr_word[29:28];
            r.data.token_length = tkl;
            r.data.code         = ps_hdr_word[23:16];
            r.data.message_id   = ps_hdr_word[15:0];
            have         = 1'b1;
            ps_remaining = {12'h000, tkl};
            ps_phase     = (tkl != 0) ? PH_TOK : PH_OPT;
          end
        end
      end
      PH_TOK, PH_VAL: begin
        r.kind          = (ps_phase == PH_TOK) ? KIND_TOKEN : KIND_VALUE;
        r.data.byte_out = b;
        have         = 1'b1;
        ps_remaining = ps_remaining - 16'd1;
        if (ps_remaining == 0) begin
          ps_phase = PH_OPT;
        end
      end
      PH_OPT: begin
        if (b == PayloadMarker) begin
          ps_phase = PH_PAY;
        end else if (ps_opt_count >= MaxOptionsDefault) begin
          ps_phase = PH_IGN;
        end else begin
          ps_length = {12'h000, b[3:0]};
          if (b[7:4] == NibbleBad) begin
            abort_packet(STAT_DELTA_15);
          end else if (b[7:4] == NibbleExt1 || b[7:4] == NibbleExt2) begin
            ps_delta     = (b[7:4] == NibbleExt1) ? Ext1Base : Ext2Base;
            ps_delta_ext = (b[7:4] == NibbleExt1) ? 2'd1 : 2'd2;
            ps_phase     = PH_EXT;
          end else begin
            ps_delta = {12'h000, b[7:4]};
            start_length(r, have);
          end
        end
      end
      PH_EXT: begin
        if (ps_delta_ext != 0) begin
          ps_delta     = ps_delta + ((ps_delta_ext == 2'd2) ? {b, 8'h00} : {8'h00, b});
          ps_delta_ext = ps_delta_ext - 2'd1;
          if (ps_delta_ext == 0) begin
            start_length(r, have);
          end
        end else if (ps_length_ext != 0) begin
          ps_length     = ps_length + ((ps_length_ext == 2'd2) ? {b, 8'h00} : {8'h00, b});
          ps_length_ext = ps_length_ext - 2'd1;
          if (ps_length_ext == 0) begin
            finish_option(r, have);
          end
        end else begin
          finish_option(r, have);
        end
      end
      PH_PAY: begin
        r.kind          = KIND_PAYLOAD;
        r.data.byte_out = b;
        have = 1'b1;
      end
      default: begin
      end
    endcase

    if (eop) begin
      case (ps_phase)
        PH_ERR:  st = ps_error;
        PH_HDR:  st = STAT_SHORT_HDR;
        PH_TOK:  st = STAT_BAD_TOKEN;
        PH_EXT:  st = STAT_SHORT_OPT;
        PH_VAL:  st = STAT_OPT_OVERRUN;
        default: st = STAT_OK;
      endcase
      if (have && st == STAT_OK) begin
        expected_records.push_back(r);
      end
      r                   = '0;
      r.kind              = KIND_END;
      r.last              = 1'b1;
      r.data.status       = st;
      r.data.option_count = (st == STAT_OK) ? ps_opt_count : 5'd0;
      expected_records.push_back(r);
      clear_parser();
    end else if (have) begin
      expected_records.push_back(r);
    end
  endtask

  // sender side
  always @(posedge clk_i) begin : drive_bytes
    wire_byte_t item;
    if (!rst_ni) begin
      clear_parser();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_records(s_axis_tdata, s_axis_tlast);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item = pending_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= item.octet;
          s_axis_tlast  <= item.eop;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver side
  always @(posedge clk_i) begin : collect_records
    rec_t got;
    rec_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_records.size() == 0) begin
          report_mismatch($sformatf("record of kind %0d with nothing expected", m_axis_tuser));
        end else begin
          want      = expected_records.pop_front();
          got.last  = m_axis_tlast;
          got.kind  = kind_e'(m_axis_tuser);
          got.data  = rec_data_t'(m_axis_tdata[$bits(rec_data_t)-1:0]);
          check_field("kind", 16'(got.kind), 16'(want.kind));
          check_field("last", 16'(got.last), 16'(want.last));
          check_field("msg_type", 16'(got.data.msg_type), 16'(want.data.msg_type));
          check_field("token_length", 16'(got.data.token_length), 16'(want.data.token_length));
          check_field("code", 16'(got.data.code), 16'(want.data.code));
          check_field("message_id", got.data.message_id, want.data.message_id);
          check_field("option_number", got.data.option_number, want.data.option_number);
          check_field("option_length", got.data.option_length, want.data.option_length);
          check_field("byte_out", 16'(got.data.byte_out), 16'(want.data.byte_out));
          check_field("option_count", 16'(got.data.option_count), 16'(want.data.option_count));
          check_field("status", 16'(got.data.status), 16'(want.data.status));
          check_field("padding", 16'(m_axis_tdata[OutDataW-1:$bits(rec_data_t)]), 16'h0000);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic queue_message();
    for (int i = 0; i < message_bytes.size(); i++) begin
      pending_bytes.push_back({message_bytes[i], i == message_bytes.size() - 1});
    end
    bytes_queued += message_bytes.size();
  endtask

  // random message, well-formed unless it ends inside a long value
  task automatic build_message();
    int         tkl;
    int         n_opt;
    int         sel;
    int         vlen;
    logic [3:0] dn;
    logic [3:0] ln;
    logic [7:0] ext;
    bit         open_value;
    message_bytes.delete();
    open_value = 1'b0;
    tkl = $urandom_range(8);
    message_bytes.push_back({CoapVersion, 2'($urandom_range(3)), 4'(tkl)});
    repeat (3 + tkl) message_bytes.push_back(8'($urandom));
    n_opt = ($urandom_range(7) == 0) ? $urandom_range(19, 14) : $urandom_range(4);
    for (int i = 0; i < n_opt && !open_value; i++) begin
      sel = $urandom_range(9);
      dn  = (sel < 6) ? 4'($urandom_range(12)) : (sel < 8) ? NibbleExt1 : NibbleExt2;
      sel = $urandom_range(11);
      ln  = (sel < 7) ? 4'($urandom_range(3)) : (sel < 9) ? 4'($urandom_range(12, 4)) :
            (sel < 11) ? NibbleExt1 : NibbleExt2;
      message_bytes.push_back({dn, ln});
      if (dn == NibbleExt1) message_bytes.push_back(8'($urandom));
      if (dn == NibbleExt2) repeat (2) message_bytes.push_back(8'($urandom));
      if (ln == NibbleExt1) begin
        ext = 8'($urandom_range(3));
        message_bytes.push_back(ext);
        vlen = 13 + ext;
      end else if (ln == NibbleExt2) begin
        // long value, the message stops inside it
        repeat (2) message_bytes.push_back(8'($urandom));
        vlen = $urandom_range(3);
        open_value = 1'b1;
      end else begin
        vlen = ln;
      end
      repeat (vlen) message_bytes.push_back(8'($urandom));
    end
    if (!open_value) begin
      sel = $urandom_range(3);
      if (sel != 0) message_bytes.push_back(PayloadMarker);
      if (sel > 1) repeat ($urandom_range(8, 1)) message_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic make_random_message();
    int sel;
    int cut;
    build_message();
    sel = $urandom_range(19);
    if (sel == 14 || sel == 15) begin
      cut = $urandom_range(message_bytes.size(), 1);
      while (message_bytes.size() > cut) void'(message_bytes.pop_back());
    end else if (sel == 16) begin
      message_bytes[$urandom_range(message_bytes.size() - 1)] = 8'($urandom);
    end else if (sel == 17) begin
      // broken first option: length nibble 15, delta nibble 12 to 15
      while (message_bytes.size() > 4 + message_bytes[0][3:0]) void'(message_bytes.pop_back());
      message_bytes.push_back({4'($urandom_range(15, 12)), NibbleBad});
      repeat ($urandom_range(2)) message_bytes.push_back(8'($urandom));
    end else if (sel == 18) begin
      message_bytes.delete();
      repeat ($urandom_range(8, 1)) message_bytes.push_back(8'($urandom));
    end else if (sel == 19) begin
      message_bytes[0] = 8'($urandom);
    end
    queue_message();
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_records.size() != 0);
  endtask

  task automatic run_random_phase(input int send_idle, input int recv_stall, input int n_bytes);
    send_idle_pct  = send_idle;
    recv_stall_pct = recv_stall;
    bytes_queued   = 0;
    while (bytes_queued < n_bytes) make_random_message();
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // short header
    message_bytes = '{8'h40};
    queue_message();
    // bad version with all ones
    message_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
    queue_message();
    // token length nine, trailing byte ignored
    message_bytes = '{8'h79, 8'h00, 8'h00, 8'h00, 8'h00};
    queue_message();
    // two-byte delta wraps, one value byte, marker as final byte gives empty payload
    message_bytes = '{8'h51, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hE1, 8'hFF, 8'hFF, 8'h7E, 8'hFF};
    queue_message();
    // length nibble 15 seen after the delta extension byte
    message_bytes = '{8'h40, 8'h00, 8'h00, 8'h00, 8'hDF, 8'h05};
    queue_message();
    wait_drained();

    run_random_phase(0, 0, 100);
    run_random_phase(46, 0, 100);
    run_random_phase(0, 46, 100);
    run_random_phase(32, 32, 100);

    recv_stall_pct = 0;
    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
